### rtl/mstt_pkg.sv
// Package for the multi-slot timer table: sizes, item kinds, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package mstt_pkg;
  localparam int unsigned SLOTS      = 16;
  localparam int unsigned OWNER_BITS = 4;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    KIND_SET     = 2'd0,
    KIND_KILL    = 2'd1,
    KIND_PROCESS = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_OUT  = 2'd2
  } state_e;

  // Command token handed from cell to cell along the chain.
  typedef struct packed {
    logic                  act;       // a scan is passing this cell
    kind_e                 kind;
    logic [31:0]           now_time;
    logic [30:0]           interval;
    logic                  repeat_req;
    logic [OWNER_BITS-1:0] owner;
    logic                  match_all;
    logic [3:0]            slot;
    logic                  done;      // set already claimed a slot upstream
  } tok_t;

  // Event reported by a cell when the token visits it.
  typedef struct packed {
    logic        hit;     // set claimed / process fired here
    logic [IDX_W-1:0] idx;
  } evt_t;
endpackage

### rtl/mstt_cell.sv
// One timer slot of the chain: holds its state and acts on the passing token.
// Depends on mstt_pkg.
`timescale 1ns / 1ps
module mstt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [mstt_pkg::IDX_W-1:0] my_idx_i,
  input  mstt_pkg::tok_t         tok_i,
  output mstt_pkg::tok_t         tok_o,
  output mstt_pkg::evt_t         evt_o
);
  logic                            valid_q, valid_d;
  logic [30:0]                     ival_q, ival_d;
  logic                            rep_q, rep_d;
  logic [mstt_pkg::OWNER_BITS-1:0] own_q, own_d;
  logic [31:0]                     start_q, start_d;
  logic [31:0]                     diff;
  logic                            due, claim, fire, kill;
  mstt_pkg::tok_t                  tok_d;

  // Due check on the wrapping signed elapsed time
  assign diff  = tok_i.now_time - start_q;
  assign due   = valid_q && (tok_i.match_all || own_q == tok_i.owner)
                 && !diff[31] && (diff[30:0] >= ival_q);
  assign claim = tok_i.act && tok_i.kind == mstt_pkg::KIND_SET && !tok_i.done && !valid_q;
  assign fire  = tok_i.act && tok_i.kind == mstt_pkg::KIND_PROCESS && due;
  assign kill  = tok_i.act && tok_i.kind == mstt_pkg::KIND_KILL
                 && tok_i.slot == 4'(my_idx_i);

  always_comb begin
    valid_d = valid_q;
    ival_d  = ival_q;
    rep_d   = rep_q;
    own_d   = own_q;
    start_d = start_q;
    if (claim) begin
      valid_d = 1'b1;
      ival_d  = tok_i.interval;
      rep_d   = tok_i.repeat_req;
      own_d   = tok_i.owner;
      start_d = tok_i.now_time;
    end else if (fire) begin
      if (rep_q) start_d = start_q + {1'b0, ival_q};
      else valid_d = 1'b0;
    end else if (kill) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ival_q  <= '0;
      rep_q   <= 1'b0;
      own_q   <= '0;
      start_q <= '0;
    end else begin
      valid_q <= valid_d;
      ival_q  <= ival_d;
      rep_q   <= rep_d;
      own_q   <= own_d;
      start_q <= start_d;
    end
  end

  // Outgoing token: mark a set as served once a slot is claimed
  always_comb begin
    tok_d      = tok_i;
    tok_d.done = tok_i.done | claim;
  end

  // Token moves one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else begin
      tok_o <= tok_d;
    end
  end

  assign evt_o.hit = claim | fire;
  assign evt_o.idx = my_idx_i;
endmodule

### rtl/multi_slot_timer_table.sv
// Top level of the multi-slot timer table: sequencer, cell chain, result FIFO.
// Depends on mstt_pkg and mstt_cell.
//
// Usage: the in channel (in_valid_i / in_stall_o) takes one item beat with
// kind, now_time, interval, repeat_req, owner, match_all and slot. The out
// channel (out_valid_o / out_stall_i) returns result beats slot_id, ok,
// fired, last. The accepted beat is registered as a command token at the head
// of the chain and then walks the SLOTS (16) cells, one cell per cycle; the
// scan length is set by the sequencer's counter. The result beats are offered
// after the scan; fired slots are queued in a FIFO of SLOTS entries during the
// scan and then drained one beat per cycle while the receiver does not stall.
// Unused kind 3 gives no beat. Reset clears every slot and empties the queue.
// No new item is taken until all of the item's results are gone; while the
// receiver stalls, the current beat holds.
`timescale 1ns / 1ps
module multi_slot_timer_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_time_i,
  input  logic [30:0] interval_i,
  input  logic        repeat_req_i,
  input  logic [3:0]  owner_i,
  input  logic        match_all_i,
  input  logic [3:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  slot_id_o,
  output logic        ok_o,
  output logic        fired_o,
  output logic        last_o
);
  localparam int unsigned N = mstt_pkg::SLOTS;
  localparam int unsigned W = mstt_pkg::IDX_W;

  mstt_pkg::state_e state_q, state_d;
  mstt_pkg::tok_t   chain [N+1];
  mstt_pkg::evt_t   evt [N];
  mstt_pkg::tok_t   head;
  logic [W-1:0]     cnt_q, cnt_d;
  mstt_pkg::kind_e  kind_q;
  logic [3:0]       slot_q;
  logic             accept;

  // Result queue, one entry per fired slot
  logic [W-1:0]     fifo [N];
  logic [mstt_pkg::CNT_W-1:0] fill_q, rd_q;
  logic             single_q;   // set/kill/empty beat
  logic [3:0]       single_id_q;
  logic             single_ok_q, set_hit_q;
  logic             out_fire;

  assign accept = in_valid_i && !in_stall_o;

  // Chain of cells
  always_comb begin
    head            = '0;
    head.act        = accept;
    head.kind       = mstt_pkg::kind_e'(kind_i);
    head.now_time   = now_time_i;
    head.interval   = interval_i;
    head.repeat_req = repeat_req_i;
    head.owner      = owner_i[mstt_pkg::OWNER_BITS-1:0];
    head.match_all  = match_all_i;
    head.slot       = slot_i;
  end

  // Token enters cell 0 in the first scan cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= head;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    mstt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (W'(g)),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1]),
      .evt_o    (evt[g])
    );
  end

  // The token reaches cell k at scan cycle k; pick that cell's event
  logic             cur_hit;
  logic [W-1:0]     cur_idx;
  always_comb begin
    cur_hit = evt[cnt_q].hit && chain[cnt_q].act;
    cur_idx = evt[cnt_q].idx;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      mstt_pkg::ST_IDLE: if (accept) begin
        state_d = mstt_pkg::ST_SCAN;
        cnt_d   = '0;
      end
      mstt_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == W'(N - 1)) state_d = mstt_pkg::ST_OUT;
      end
      mstt_pkg::ST_OUT: begin
        if (kind_q == mstt_pkg::KIND_NONE) state_d = mstt_pkg::ST_IDLE;
        else if (out_fire && last_o) state_d = mstt_pkg::ST_IDLE;
      end
      default: state_d = mstt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o  = (state_q != mstt_pkg::ST_IDLE);
    out_valid_o = (state_q == mstt_pkg::ST_OUT) && (kind_q != mstt_pkg::KIND_NONE);
    if (single_q) begin
      slot_id_o = single_id_q;
      ok_o      = single_ok_q;
      fired_o   = 1'b0;
      last_o    = 1'b1;
    end else begin
      slot_id_o = 4'(fifo[rd_q[W-1:0]]);
      ok_o      = 1'b0;
      fired_o   = 1'b1;
      last_o    = (rd_q + 1'b1 == fill_q);
    end
  end
  assign out_fire = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mstt_pkg::ST_IDLE;
      cnt_q   <= '0;
      kind_q  <= mstt_pkg::KIND_NONE;
      fill_q  <= '0;
      rd_q    <= '0;
      set_hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        kind_q    <= mstt_pkg::kind_e'(kind_i);
        fill_q    <= '0;
        rd_q      <= '0;
        set_hit_q <= 1'b0;
      end
      if (state_q == mstt_pkg::ST_SCAN && cur_hit) begin
        if (kind_q == mstt_pkg::KIND_PROCESS) fill_q <= fill_q + 1'b1;
        else set_hit_q <= 1'b1;
      end
      if (out_fire) rd_q <= rd_q + 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) slot_q <= slot_i;
    if (state_q == mstt_pkg::ST_SCAN && cur_hit) begin
      fifo[fill_q[W-1:0]] <= cur_idx;
      if (kind_q == mstt_pkg::KIND_SET) single_id_q <= 4'(cur_idx);
    end
    if (state_q == mstt_pkg::ST_SCAN && cnt_q == W'(N - 1)) begin
      case (kind_q)
        mstt_pkg::KIND_SET: begin
          single_q    <= 1'b1;
          single_ok_q <= set_hit_q | cur_hit;
          // table full: report slot 0
          if (!(set_hit_q | cur_hit)) single_id_q <= '0;
        end
        mstt_pkg::KIND_KILL: begin
          single_q    <= 1'b1;
          single_id_q <= slot_q;
          single_ok_q <= ({1'b0, slot_q} < 5'(N));
        end
        mstt_pkg::KIND_PROCESS: begin
          single_q    <= !(fill_q != '0 || cur_hit);
          single_id_q <= '0;
          single_ok_q <= 1'b0;
        end
        default: begin
          single_q    <= 1'b1;
          single_id_q <= '0;
          single_ok_q <= 1'b0;
        end
      endcase
    end
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != mstt_pkg::ST_IDLE |-> !accept) else $error("accept while busy");
  a_out_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == mstt_pkg::ST_OUT) else $error("valid outside OUT");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mstt_pkg::CNT_W'(N)) else $error("queue overflow");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == mstt_pkg::ST_SCAN && cnt_q == '0) else $error("scan start");
endmodule

### dv/tb.sv
// Testbench for multi_slot_timer_table: directed and random set, kill and
// process beats checked against a behavioral timer table. Depends on mstt_pkg.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned MAX_FIRE   = 16;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_WAIT = 40;

  typedef struct packed {
    logic [3:0] slot_id;
    logic       ok;
    logic       fired;
    logic       last;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = mstt_pkg::KIND_SET;
  logic [31:0] now_time_i = '0;
  logic [30:0] interval_i = '0;
  logic        repeat_req_i = 1'b0;
  logic [3:0]  owner_i = '0;
  logic        match_all_i = 1'b0;
  logic [3:0]  slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  slot_id_o;
  logic        ok_o;
  logic        fired_o;
  logic        last_o;

  multi_slot_timer_table dut (.*);

  // Shadow timer table
  logic                            tm_valid [mstt_pkg::SLOTS];
  logic [30:0]                     tm_ival  [mstt_pkg::SLOTS];
  logic                            tm_rep   [mstt_pkg::SLOTS];
  logic [mstt_pkg::OWNER_BITS-1:0] tm_owner [mstt_pkg::SLOTS];
  logic [31:0]                     tm_start [mstt_pkg::SLOTS];

  res_t        expected_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          hold_off = 1'b0;   // long receiver stall request
  logic [31:0] clock_ms = '0;     // running tick base for stimulus

  initial forever #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Append one expected beat
  function automatic void queue_beat(input res_t r);
    expected_q = {expected_q, r};
  endfunction

  // Predict the result beats of one item
  task automatic predict_timers(input logic [1:0] kind, input logic [31:0] now,
                                input logic [30:0] ival, input logic rep,
                                input logic [3:0] own, input logic all,
                                input logic [3:0] idx);
    int   n;
    logic [31:0] elapsed;
    res_t r;
    n = 0;
    case (kind)
      mstt_pkg::KIND_SET: begin
        r = '{slot_id: 4'd0, ok: 1'b0, fired: 1'b0, last: 1'b1};
        for (int i = 0; i < mstt_pkg::SLOTS; i++) begin
          if (!tm_valid[i]) begin
            tm_valid[i] = 1'b1;
            tm_ival[i]  = ival;
            tm_rep[i]   = rep;
            tm_owner[i] = own[mstt_pkg::OWNER_BITS-1:0];
            tm_start[i] = now;
            r.slot_id = 4'(i);
            r.ok = 1'b1;
            break;
          end
        end
        queue_beat(r);
      end
      mstt_pkg::KIND_KILL: begin
        r = '{slot_id: idx, ok: (idx < mstt_pkg::SLOTS), fired: 1'b0, last: 1'b1};
        if (idx < mstt_pkg::SLOTS) tm_valid[idx] = 1'b0;
        queue_beat(r);
      end
      mstt_pkg::KIND_PROCESS: begin
        for (int i = 0; i < mstt_pkg::SLOTS && n < MAX_FIRE; i++) begin
          if (!tm_valid[i]) continue;
          if (!all && tm_owner[i] != own[mstt_pkg::OWNER_BITS-1:0]) continue;
          elapsed = now - tm_start[i];
          if (elapsed[31] || elapsed < {1'b0, tm_ival[i]}) continue;
          if (tm_rep[i]) tm_start[i] = now - (elapsed - {1'b0, tm_ival[i]});
          else tm_valid[i] = 1'b0;
          queue_beat('{slot_id: 4'(i), ok: 1'b0, fired: 1'b1, last: 1'b0});
          n++;
        end
        if (n == 0) queue_beat('{slot_id: 4'd0, ok: 1'b0, fired: 1'b0, last: 1'b1});
        else expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned short_or_long_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Send one item beat; prediction happens at acceptance
  task automatic send_item(input logic [1:0] kind, input logic [31:0] now,
                           input logic [30:0] ival, input logic rep,
                           input logic [3:0] own, input logic all,
                           input logic [3:0] idx, input bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? short_or_long_gap() : 0;
    // wait past the previous beat's valid drop, plus the random gap
    repeat (gap + 1) @(negedge clk_i);
    kind_i <= kind; now_time_i <= now; interval_i <= ival; repeat_req_i <= rep;
    owner_i <= own; match_all_i <= all; slot_i <= idx; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_timers(kind, now, ival, rep, own, all, idx);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Receiver stall pattern
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        n = short_or_long_gap();
        out_stall_i <= (n != 0);
        repeat (n > 0 ? n - 1 : 0) @(negedge clk_i);
      end else out_stall_i <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{slot_id: slot_id_o, ok: ok_o, fired: fired_o, last: last_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  task automatic wait_idle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Directed: fill the table, overflow, kills of a live and a free slot, kind 3
  task automatic test_fill_and_kill();
    for (int i = 0; i < mstt_pkg::SLOTS; i++)
      send_item(mstt_pkg::KIND_SET, 32'd100, (i == 0) ? 31'h7FFF_FFFF : 31'(i * 10),
                i[0], 4'(i), 1'b0, 4'd0);
    send_item(mstt_pkg::KIND_SET, 32'hFFFF_FFFF, 31'd5, 1'b1, 4'hF, 1'b1, 4'hF);
    send_item(mstt_pkg::KIND_KILL, 32'd0, 31'd0, 1'b0, 4'd0, 1'b0, 4'd15);
    send_item(mstt_pkg::KIND_KILL, 32'd0, 31'd0, 1'b0, 4'd0, 1'b0, 4'd15);
    send_item(mstt_pkg::KIND_NONE, 32'd0, 31'd0, 1'b0, 4'd0, 1'b0, 4'd0);
    send_item(mstt_pkg::KIND_KILL, 32'd0, 31'd0, 1'b0, 4'd0, 1'b0, 4'd0);
    wait_idle();
  endtask

  // Directed: owner filter, match_all, nothing due, negative elapsed, wrap
  task automatic test_process();
    send_item(mstt_pkg::KIND_PROCESS, 32'd50, 31'd0, 1'b0, 4'd3, 1'b0, 4'd0);
    send_item(mstt_pkg::KIND_PROCESS, 32'd130, 31'd0, 1'b0, 4'd3, 1'b0, 4'd0);
    send_item(mstt_pkg::KIND_PROCESS, 32'd300, 31'd0, 1'b0, 4'd0, 1'b1, 4'd0);
    send_item(mstt_pkg::KIND_PROCESS, 32'h8000_0100, 31'd0, 1'b0, 4'd0, 1'b1, 4'd0);
    for (int i = 0; i < mstt_pkg::SLOTS; i++)
      send_item(mstt_pkg::KIND_KILL, 32'd0, 31'd0, 1'b0, 4'd0, 1'b0, 4'(i));
    send_item(mstt_pkg::KIND_SET, 32'hFFFF_FFF0, 31'd0, 1'b1, 4'd9, 1'b0, 4'd0);
    send_item(mstt_pkg::KIND_PROCESS, 32'h0000_0004, 31'd0, 1'b0, 4'd9, 1'b0, 4'd0);
    wait_idle();
  endtask

  // Random mix, mostly sets and processes with small advancing times
  task automatic test_random(input int unsigned count);
    logic [1:0]  kind;
    logic [31:0] now;
    logic [30:0] ival;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? mstt_pkg::KIND_SET : (pick < 55) ? mstt_pkg::KIND_KILL :
             (pick < 97) ? mstt_pkg::KIND_PROCESS : mstt_pkg::KIND_NONE;
      clock_ms = clock_ms + $urandom_range(0, 40);
      now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;
      ival = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 60));
      send_item(kind, now, ival, 1'($urandom()), 4'($urandom_range(0, 3)) |
                (($urandom_range(0, 7) == 0) ? 4'hC : 4'h0),
                1'($urandom_range(0, 2) == 0), 4'($urandom()));
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int unsigned held;
    hold_off = 1'b1;
    fork
      begin
        held = 0;
        while (held < 300) begin
          @(negedge clk_i);
          held++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_item(mstt_pkg::KIND_PROCESS, clock_ms, 31'd0, 1'b0, 4'd0, 1'b1, 4'd0, 1'b0);
    join
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < mstt_pkg::SLOTS; i++) begin
      tm_valid[i] = 1'b0; tm_ival[i] = '0; tm_rep[i] = 1'b0;
      tm_owner[i] = '0; tm_start[i] = '0;
    end
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_fill_and_kill();
    test_process();
    test_random(50);
    test_backpressure();
    test_random(50);
    if (mismatches == 0 && expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
